// ----- src/pid_sampled_controller_defines.svh -----
// ----------------------------------------------------------------------------
// PID sampled controller assertion macros
// Shared property shapes for the checkers of the controller, clocked on clk
// and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PID_SAMPLED_CONTROLLER_DEFINES_SVH
`define PID_SAMPLED_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pidsc_pkg.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller package
// Widths, constants, register indexes, control structs and the sequencer
// state type shared by the controller modules.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned FracW    = 8;
  localparam int unsigned ValW     = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned DiffW    = 18;
  localparam int unsigned AccW     = 26;
  localparam int unsigned AccSumW  = 50;
  localparam int unsigned DriveW   = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PTermW   = 25;
  localparam int unsigned ITermW   = 24;
  localparam int unsigned SumW     = 38;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulAW    = 26;
  localparam int unsigned MulBW    = 33;
  localparam int unsigned ProdW    = MulAW + MulBW;

  // Shared divider: signed dividend, unsigned divisor, two quotient bits a step.
  localparam int unsigned DivNW    = 36;
  localparam int unsigned DivDW    = 32;
  localparam int unsigned DivQW    = DivNW + 1;
  localparam int unsigned DivSteps = DivNW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic signed [AccW-1:0]  IntegLimit   = 26'sd25600000;
  localparam logic signed [MulBW-1:0] DerivScale   = 33'sd1000;
  localparam logic [DivDW-1:0]        IntegDivisor = 32'd1000;

  localparam logic signed [15:0] GainPropRst  = 16'sd512;
  localparam logic signed [15:0] GainIntegRst = 16'sd128;
  localparam logic signed [15:0] GainDerivRst = 16'sd26;
  localparam logic [15:0]        PeriodRst    = 16'd100;
  localparam logic signed [23:0] FloorRst     = 24'sd0;
  localparam logic signed [23:0] CeilingRst   = 24'sd65280;

  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_FLOOR      = 3'd4,
    REG_CEILING    = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_RESET   = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic [15:0]        sample_period_ms;
    logic signed [23:0] drive_floor;
    logic signed [23:0] drive_ceiling;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [DivNW-1:0] dividend;
    logic [DivDW-1:0]        divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_IE,
    ST_ACC,
    ST_MUL_I,
    ST_DIVI_GO,
    ST_DIVI_WAIT,
    ST_MUL_D,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_SUM,
    ST_OUT
  } ctl_state_t;

endpackage

// ----- src/pidsc_regs.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller configuration registers
// APB-style register file holding the gains, sample period and drive clamps.
// ----------------------------------------------------------------------------
module pidsc_regs import pidsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx    = cfg_idx_t'(paddr[CfgAddrW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_PROP:  cfg_nxt.gain_prop        = pwdata[15:0];
        REG_GAIN_INTEG: cfg_nxt.gain_integ       = pwdata[15:0];
        REG_GAIN_DERIV: cfg_nxt.gain_deriv       = pwdata[15:0];
        REG_PERIOD:     cfg_nxt.sample_period_ms = pwdata[15:0];
        REG_FLOOR:      cfg_nxt.drive_floor      = pwdata[23:0];
        REG_CEILING:    cfg_nxt.drive_ceiling    = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop        <= GainPropRst;
      cfg_r.gain_integ       <= GainIntegRst;
      cfg_r.gain_deriv       <= GainDerivRst;
      cfg_r.sample_period_ms <= PeriodRst;
      cfg_r.drive_floor      <= FloorRst;
      cfg_r.drive_ceiling    <= CeilingRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_PROP:  prdata = {{16{cfg_r.gain_prop[15]}}, cfg_r.gain_prop};
      REG_GAIN_INTEG: prdata = {{16{cfg_r.gain_integ[15]}}, cfg_r.gain_integ};
      REG_GAIN_DERIV: prdata = {{16{cfg_r.gain_deriv[15]}}, cfg_r.gain_deriv};
      REG_PERIOD:     prdata = {16'd0, cfg_r.sample_period_ms};
      REG_FLOOR:      prdata = {{8{cfg_r.drive_floor[23]}}, cfg_r.drive_floor};
      REG_CEILING:    prdata = {{8{cfg_r.drive_ceiling[23]}}, cfg_r.drive_ceiling};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- src/pidsc_mul.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller shared multiplier
// Signed multiplier with a registered product, used for every product term.
// ----------------------------------------------------------------------------
module pidsc_mul import pidsc_pkg::*; (
  input  logic                    clk,
  input  mul_req_t                req,
  output logic signed [ProdW-1:0] prod
);

  logic signed [ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= ProdW'(req.a * req.b);
    end
  end

  assign prod = prod_r;

endmodule

// ----- src/pidsc_div.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller shared divider
// Radix-4 restoring divider giving the floor quotient of a signed dividend
// by an unsigned nonzero divisor, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pidsc_div import pidsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_req_t                req,
  output logic                    done,
  output logic signed [DivQW-1:0] quotient
);

  logic               active_r;
  logic               done_r;
  logic [DivCntW-1:0] cnt_r;
  logic               neg_r;
  logic [DivDW-1:0]   div_r;
  logic [DivDW-1:0]   rem_r;
  logic [DivNW-1:0]   quo_r;

  logic [DivNW-1:0]   mag;
  logic [DivDW:0]     t1;
  logic [DivDW:0]     t1_sub;
  logic               b1;
  logic [DivDW-1:0]   r1;
  logic [DivDW:0]     t2;
  logic [DivDW:0]     t2_sub;
  logic               b2;
  logic [DivDW-1:0]   r2;
  logic               rnd;
  logic [DivQW-1:0]   q_mag;

  assign mag = req.dividend[DivNW-1] ? DivNW'(~req.dividend + 1'b1)
                                     : DivNW'(req.dividend);

  // Two restoring steps per cycle; the remainder always stays below the divisor.
  assign t1     = {rem_r, quo_r[DivNW-1]};
  assign t1_sub = t1 - {1'b0, div_r};
  assign b1     = (t1 >= {1'b0, div_r});
  assign r1     = b1 ? t1_sub[DivDW-1:0] : t1[DivDW-1:0];
  assign t2     = {r1, quo_r[DivNW-2]};
  assign t2_sub = t2 - {1'b0, div_r};
  assign b2     = (t2 >= {1'b0, div_r});
  assign r2     = b2 ? t2_sub[DivDW-1:0] : t2[DivDW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= DivCntW'(DivSteps - 1);
      end else if (active_r) begin
        if (cnt_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[DivNW-1];
      div_r <= req.divisor;
      rem_r <= '0;
      quo_r <= mag;
    end else if (active_r) begin
      rem_r <= r2;
      quo_r <= {quo_r[DivNW-3:0], b1, b2};
    end
  end

  // Negative dividends round toward minus infinity.
  assign rnd      = (rem_r != '0);
  assign q_mag    = {1'b0, quo_r} + {{(DivQW-1){1'b0}}, rnd};
  assign quotient = neg_r ? DivQW'(~q_mag + 1'b1) : DivQW'({1'b0, quo_r});
  assign done     = done_r;

endmodule

// ----- src/pid_sampled_controller.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller
// Sample-gated fixed-point PID controller with a clamped integral, built
// around one shared multiplier and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
// Each input transfer is a compute request or a controller reset, selected by
// in_tuser. A reset clears the integral, the previous error and the held drive,
// stamps the time and returns drive 0 with updated low. A compute request whose
// timestamp is less than sample_period_ms after the last update returns the
// held drive with updated low; both of these go from the idle state straight to
// the output state. A full update runs the multiplier for error times elapsed
// time, the proportional, integral and derivative products, and the divider
// twice (integral scaling by 1000 and the derivative division by elapsed time),
// each division giving two quotient bits per cycle; with zero elapsed time the
// derivative division is skipped and the derivative term is zero. in_tready is
// low while an item is being worked on. A finished result sits in the output
// register, so the next transfer can be taken while the previous result waits
// for out_tready. Values and gains are signed Q8.8, drive and its clamps signed
// Q16.8; each term is floored on its own before the clamped sum.
// ----------------------------------------------------------------------------
module pid_sampled_controller import pidsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,    // target_value[15:0], measured_value[31:16],
                                           // time_ms[63:32]
  input  logic                in_tuser,    // opcode[0]: 0 compute, 1 reset
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,   // drive[23:0]
  output logic                out_tuser,   // updated[0]
  // Configuration port.
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t       cfg;
  mul_req_t   mul_req;
  div_req_t   div_req;
  logic signed [ProdW-1:0] prod;
  logic                    div_done;
  logic signed [DivQW-1:0] div_quo;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Controller state.
  logic signed [AccW-1:0]   integ_r;
  logic signed [ErrW-1:0]   prev_err_r;
  logic signed [DriveW-1:0] held_r;
  logic [TimeW-1:0]         last_ms_r;

  // Per-item working registers.
  logic signed [ErrW-1:0]   err_r;
  logic [TimeW-1:0]         elapsed_r;
  logic [TimeW-1:0]         now_r;
  logic signed [PTermW-1:0] p_r;
  logic signed [ITermW-1:0] i_r;
  logic signed [DivQW-1:0]  d_r;
  logic [DriveW-1:0]        res_drive_r;
  logic                     res_upd_r;

  // Output register.
  logic                     out_tvalid_r;
  logic [DriveW-1:0]        out_tdata_r;
  logic                     out_tuser_r;

  logic [TimeW-1:0]         in_time;
  logic [TimeW-1:0]         elapsed_c;
  logic                     held_c;
  logic signed [ErrW-1:0]   err_c;
  logic signed [DiffW-1:0]  diff;
  logic signed [AccSumW-1:0] acc_sum;
  logic signed [AccW-1:0]   acc_clamped;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   floor_x;
  logic signed [SumW-1:0]   ceil_x;
  logic signed [DriveW-1:0] sum_clamped;
  logic                     slot_free;
  logic                     in_take;

  pidsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pidsc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  pidsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Gate check and error are formed straight from the input transfer.
  assign in_time   = in_tdata[63:32];
  assign elapsed_c = in_time - last_ms_r;
  assign held_c    = (elapsed_c < {16'd0, cfg.sample_period_ms});
  assign err_c     = {in_tdata[15], in_tdata[15:0]} - {in_tdata[31], in_tdata[31:16]};
  assign diff      = {err_r[ErrW-1], err_r} - {prev_err_r[ErrW-1], prev_err_r};
  assign in_take   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  // Integral: add error times elapsed milliseconds and clamp to +-100 V*s.
  assign acc_sum = {{(AccSumW-AccW){integ_r[AccW-1]}}, integ_r} + prod[AccSumW-1:0];
  always_comb begin
    priority if (acc_sum > AccSumW'(IntegLimit)) begin
      acc_clamped = IntegLimit;
    end else if (acc_sum < -AccSumW'(IntegLimit)) begin
      acc_clamped = -IntegLimit;
    end else begin
      acc_clamped = acc_sum[AccW-1:0];
    end
  end

  // Output clamp; the floor wins when the limits cross.
  assign sum = {{(SumW-PTermW){p_r[PTermW-1]}}, p_r}
             + {{(SumW-ITermW){i_r[ITermW-1]}}, i_r}
             + {{(SumW-DivQW){d_r[DivQW-1]}}, d_r};
  assign floor_x = {{(SumW-DriveW){cfg.drive_floor[DriveW-1]}}, cfg.drive_floor};
  assign ceil_x  = {{(SumW-DriveW){cfg.drive_ceiling[DriveW-1]}}, cfg.drive_ceiling};
  always_comb begin
    priority if (sum < floor_x) begin
      sum_clamped = cfg.drive_floor;
    end else if (sum > ceil_x) begin
      sum_clamped = cfg.drive_ceiling;
    end else begin
      sum_clamped = sum[DriveW-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_RESET || held_c) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MUL_IE;
          end
        end
      end
      ST_MUL_IE:    state_nxt = ST_ACC;
      ST_ACC:       state_nxt = ST_MUL_I;
      ST_MUL_I:     state_nxt = ST_DIVI_GO;
      ST_DIVI_GO:   state_nxt = ST_DIVI_WAIT;
      ST_DIVI_WAIT: if (div_done) state_nxt = ST_MUL_D;
      ST_MUL_D:     state_nxt = ST_DIVD_GO;
      ST_DIVD_GO: begin
        if (elapsed_r == '0) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_DIVD_WAIT;
        end
      end
      ST_DIVD_WAIT: if (div_done) state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_OUT;
      ST_OUT:       if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: operand steering for the shared units.
  always_comb begin
    in_tready        = 1'b0;
    mul_req.en       = 1'b0;
    mul_req.a        = '0;
    mul_req.b        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod[DivNW+FracW-1:FracW];
    div_req.divisor  = IntegDivisor;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MUL_IE: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MulAW-ErrW){err_r[ErrW-1]}}, err_r};
        mul_req.b  = {1'b0, elapsed_r};
      end
      ST_ACC: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MulAW-ValW){cfg.gain_prop[ValW-1]}}, cfg.gain_prop};
        mul_req.b  = {{(MulBW-ErrW){err_r[ErrW-1]}}, err_r};
      end
      ST_MUL_I: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MulAW-ValW){cfg.gain_integ[ValW-1]}}, cfg.gain_integ};
        mul_req.b  = {{(MulBW-AccW){integ_r[AccW-1]}}, integ_r};
      end
      ST_DIVI_GO: begin
        div_req.start = 1'b1;
        mul_req.en    = 1'b1;
        mul_req.a     = {{(MulAW-ValW){cfg.gain_deriv[ValW-1]}}, cfg.gain_deriv};
        mul_req.b     = DerivScale;
      end
      ST_MUL_D: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[MulAW-1:0];
        mul_req.b  = {{(MulBW-DiffW){diff[DiffW-1]}}, diff};
      end
      ST_DIVD_GO: begin
        div_req.start   = (elapsed_r != '0);
        div_req.divisor = elapsed_r;
      end
      default: ;
    endcase
  end

  // Control and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      held_r       <= '0;
      last_ms_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && slot_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_take && in_tuser == OP_RESET) begin
        integ_r    <= '0;
        prev_err_r <= '0;
        held_r     <= '0;
        last_ms_r  <= in_time;
      end
      if (state_r == ST_ACC) begin
        integ_r <= acc_clamped;
      end
      if (state_r == ST_SUM) begin
        held_r     <= sum_clamped;
        prev_err_r <= err_r;
        last_ms_r  <= now_r;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      err_r     <= err_c;
      elapsed_r <= elapsed_c;
      now_r     <= in_time;
      res_upd_r <= 1'b0;
      if (in_tuser == OP_RESET) begin
        res_drive_r <= '0;
      end else begin
        res_drive_r <= held_r;
      end
    end
    if (state_r == ST_MUL_I) begin
      p_r <= prod[PTermW+FracW-1:FracW];
    end
    if (state_r == ST_DIVI_WAIT && div_done) begin
      i_r <= div_quo[ITermW-1:0];
    end
    if (state_r == ST_DIVD_GO && elapsed_r == '0) begin
      d_r <= '0;
    end
    if (state_r == ST_DIVD_WAIT && div_done) begin
      d_r <= div_quo;
    end
    if (state_r == ST_SUM) begin
      res_drive_r <= sum_clamped;
      res_upd_r   <= 1'b1;
    end
    if (state_r == ST_OUT && slot_free) begin
      out_tdata_r <= res_drive_r;
      out_tuser_r <= res_upd_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- src/pidsc_chk.sv -----
// ----------------------------------------------------------------------------
// PID sampled controller port checker
// Watches the stream ports of the controller and checks hold, occupancy and
// the one-item-at-a-time behavior; bound to every controller instance.
// ----------------------------------------------------------------------------
`include "pid_sampled_controller_defines.svh"

module pidsc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  logic        in_acc;
  logic        out_acc;
  logic        out_wait;
  logic [24:0] out_pay;
  logic [1:0]  pend_r;
  logic [1:0]  pend_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign out_wait = out_tvalid && !out_tready;
  assign out_pay  = {out_tuser, out_tdata};

  // Items taken in whose result has not yet been transferred out.
  always_comb begin
    unique case ({in_acc, out_acc})
      2'b10:   pend_nxt = pend_r + 2'd1;
      2'b01:   pend_nxt = pend_r - 2'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PIDSC_ASSERT_NXT(a_out_hold, out_wait, out_tvalid && $stable(out_pay), "stalled result changed")
  `PIDSC_ASSERT_NXT(a_busy_after_take, in_acc, !in_tready, "input taken while an item is in work")
  `PIDSC_ASSERT_NOW(a_out_has_item, out_tvalid, pend_r != 2'd0, "result offered without an item")
  `PIDSC_ASSERT_NOW(a_two_max, in_acc, pend_r != 2'd2, "more than two items outstanding")

endmodule

bind pid_sampled_controller pidsc_chk u_pidsc_chk (.*);

// ----- tb/tb_pid_sampled_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID sampled controller testbench
// Drives compute and reset requests into the controller over the input
// stream, predicts every result with an independent fixed-point model of the
// controller, and checks each result transfer against the oldest prediction.
// The run moves through several register settings and pacing mixes.
// ----------------------------------------------------------------------------
module tb_pid_sampled_controller;
  import pidsc_pkg::*;

  // Run length guard, set well above the slowest legal run with the heaviest
  // sender idling and receiver stalls.
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned ItemsPerRun  = 300;

  // One input request as the controller sees it.
  typedef struct packed {
    opcode_t     op;
    logic [15:0] target;
    logic [15:0] measured;
    logic [31:0] stamp_ms;
  } ctl_request_t;

  // One result transfer.
  typedef struct packed {
    logic [23:0] drive;
    logic        updated;
  } ctl_result_t;

  // Every input of the controller starts from a known value.
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata    = '0;  // target_value[15:0], measured_value[31:16],
                                          // time_ms[63:32]
  logic                in_tuser    = 1'b0;  // opcode[0]
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [23:0]         out_tdata;           // drive[23:0]
  logic                out_tuser;           // updated[0]
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  pid_sampled_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file, kept in step with every write.
  logic signed [15:0] kp_q88       = GainPropRst;
  logic signed [15:0] ki_q88       = GainIntegRst;
  logic signed [15:0] kd_q88       = GainDerivRst;
  logic [15:0]        period_ms    = PeriodRst;
  logic signed [23:0] floor_q168   = FloorRst;
  logic signed [23:0] ceiling_q168 = CeilingRst;

  // Predicted controller state.
  longint      integ_acc      = 0;
  longint      prev_err       = 0;
  logic [23:0] held_drive     = '0;
  logic [31:0] last_update_ms = '0;

  // Request backlog for the driver and predicted results for the monitor.
  ctl_request_t request_backlog_q[$];
  ctl_result_t  drive_expect_q[$];

  int unsigned  cycle_count       = 0;
  int unsigned  error_count       = 0;
  int unsigned  requests_queued   = 0;
  int unsigned  requests_taken    = 0;
  int unsigned  resets_taken      = 0;
  int unsigned  results_seen      = 0;
  int unsigned  updates_seen      = 0;
  int unsigned  sender_idle_pct   = 0;
  int unsigned  receiver_stall_pct = 0;
  logic [31:0]  gen_ms            = '0;

  // Quotient rounded toward minus infinity; divisors here are always positive.
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Works out the result of one accepted request and advances the predicted
  // controller state. Each of P, I and D is floored on its own before the sum
  // is clamped, and the floor clamp wins when the limits are inverted.
  function automatic ctl_result_t predict_drive(ctl_request_t req);
    ctl_result_t res;
    logic [31:0] elapsed;
    longint      span, err, acc, kp, ki, kd;
    longint      p_term, i_term, d_term, total, lo, hi;
    res.drive   = held_drive;
    res.updated = 1'b0;
    if (req.op == OP_RESET) begin
      integ_acc      = 0;
      prev_err       = 0;
      held_drive     = '0;
      last_update_ms = req.stamp_ms;
      res.drive      = '0;
      return res;
    end
    // Elapsed time wraps modulo 2^32 like the timestamp itself.
    elapsed = req.stamp_ms - last_update_ms;
    if (elapsed < period_ms) return res;
    last_update_ms = req.stamp_ms;
    span = elapsed;
    err  = longint'($signed(req.target)) - longint'($signed(req.measured));
    acc  = integ_acc + err * span;
    if (acc > longint'(IntegLimit)) acc = longint'(IntegLimit);
    if (acc < -longint'(IntegLimit)) acc = -longint'(IntegLimit);
    integ_acc = acc;
    kp = kp_q88;
    ki = ki_q88;
    kd = kd_q88;
    // Q8.8 times Q8.8 back to Q16.8; the integral is in V*ms, hence 256 * 1000.
    p_term = floor_quot(kp * err, 256);
    i_term = floor_quot(ki * acc, 256000);
    d_term = 0;
    if (span != 0) d_term = floor_quot(kd * (err - prev_err) * 1000, 256 * span);
    prev_err = err;
    total = p_term + i_term + d_term;
    lo    = floor_q168;
    hi    = ceiling_q168;
    if (total < lo) total = lo;
    else if (total > hi) total = hi;
    held_drive  = total[23:0];
    res.drive   = held_drive;
    res.updated = 1'b1;
    return res;
  endfunction

  task automatic flag_error(string what);
    error_count++;
    if (error_count <= ReportLimit) $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  // Run guard. A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, drive_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Input driver. It takes requests from the backlog and holds each one on
  // the bus until the transfer. The prediction is made at the edge of the
  // transfer, while the register shadow matches what the controller holds.
  // When the sender is set to idle, each free cycle stays empty with the
  // given chance, so the next request shows up at any point of the
  // controller's busy period.
  ctl_request_t live_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_expect_q.push_back(predict_drive(live_req));
        requests_taken++;
        if (live_req.op == OP_RESET) resets_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_backlog_q.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          live_req = request_backlog_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {live_req.stamp_ms, live_req.measured, live_req.target};
          in_tuser  <= live_req.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every result transfer is matched against the oldest
  // prediction, field by field. Each cycle stalls with the given chance.
  ctl_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) updates_seen++;
        if (drive_expect_q.size() == 0) begin
          flag_error($sformatf("result transfer with none expected: drive %0d updated %0b",
                               $signed(out_tdata), out_tuser));
        end else begin
          want = drive_expect_q.pop_front();
          if (out_tdata !== want.drive)
            flag_error($sformatf("drive expected %0d, got %0d",
                                 $signed(want.drive), $signed(out_tdata)));
          if (out_tuser !== want.updated)
            flag_error($sformatf("updated expected %0b, got %0b", want.updated, out_tuser));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Register write: setup cycle, then access cycle until pready. The shadow
  // follows only after the access edge. Writes are issued only with nothing
  // in flight, so no prediction can see a half-applied setting.
  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_PROP:  kp_q88       = value[15:0];
      REG_GAIN_INTEG: ki_q88       = value[15:0];
      REG_GAIN_DERIV: kd_q88       = value[15:0];
      REG_PERIOD:     period_ms    = value[15:0];
      REG_FLOOR:      floor_q168   = value[23:0];
      REG_CEILING:    ceiling_q168 = value[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(int kp, int ki, int kd, int period, int lo, int hi);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_PERIOD, period);
    write_reg(REG_FLOOR, lo);
    write_reg(REG_CEILING, hi);
  endtask

  task automatic queue_request(opcode_t op, logic [15:0] tgt, logic [15:0] meas,
                               logic [31:0] stamp);
    ctl_request_t req;
    req.op       = op;
    req.target   = tgt;
    req.measured = meas;
    req.stamp_ms = stamp;
    request_backlog_q.push_back(req);
    requests_queued++;
  endtask

  // Holds off until every queued request has been taken and every predicted
  // result has been seen.
  task automatic settle_all();
    while (requests_queued != requests_taken || drive_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // Random traffic follows a running clock so that most requests land near
  // the sample period, where held and fresh updates alternate. The rest are
  // exact-period hits, zero elapsed time, wild jumps across the wrap and
  // occasional controller resets.
  task automatic queue_random_request();
    logic [15:0] tgt, meas;
    logic [31:0] advance;
    tgt  = $urandom;
    meas = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                       : 16'(tgt + $urandom_range(0, 511) - 256);
    if ($urandom_range(0, 99) < 4) begin
      if ($urandom_range(0, 3) == 0) gen_ms = $urandom;
      else gen_ms += $urandom_range(0, 50);
      queue_request(OP_RESET, tgt, meas, gen_ms);
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: advance = period_ms + $urandom_range(0, 300);
      4, 5:       advance = (period_ms == 0) ? 32'd0 : $urandom_range(0, period_ms - 1);
      6:          advance = period_ms;
      7:          advance = 32'd0;
      8:          advance = $urandom;
      default:    advance = period_ms + $urandom_range(0, 100000);
    endcase
    gen_ms += advance;
    queue_request(OP_COMPUTE, tgt, meas, gen_ms);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) queue_random_request();
    settle_all();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values. The first request comes at time
    // zero and is held; then the largest positive and negative errors hit
    // the clamps, a jump across the wrap saturates the integral, and a reset
    // just below the wrap is followed by held and fresh updates after it.
    queue_request(OP_COMPUTE, 16'h0000, 16'h0000, 32'd0);
    queue_request(OP_COMPUTE, 16'h7FFF, 16'h8000, 32'd100);
    queue_request(OP_COMPUTE, 16'h7FFF, 16'h8000, 32'd150);
    queue_request(OP_COMPUTE, 16'h8000, 16'h7FFF, 32'd250);
    queue_request(OP_COMPUTE, 16'h0100, 16'h0000, 32'hFFFF_FFFF);
    queue_request(OP_RESET,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
    queue_request(OP_COMPUTE, 16'h0200, 16'h0100, 32'h0000_0050);
    queue_request(OP_COMPUTE, 16'h0200, 16'h0100, 32'h0000_0054);
    queue_request(OP_COMPUTE, 16'h1234, 16'h1234, 32'h0000_00B8);
    settle_all();

    // Zero period with the widest clamps and the largest gains: repeated
    // timestamps give zero elapsed time, where the derivative drops out.
    configure(32767, 32767, 32767, 0, -8388608, 8388607);
    queue_request(OP_COMPUTE, 16'h1000, 16'h0000, 32'd1000);
    queue_request(OP_COMPUTE, 16'h1000, 16'h0000, 32'd1000);
    queue_request(OP_COMPUTE, 16'h8000, 16'h7FFF, 32'd1000);
    queue_request(OP_COMPUTE, 16'h7FFF, 16'h8000, 32'd1001);
    settle_all();

    // Most negative gains with the floor above the ceiling: a low sum must
    // come out as the floor and a high one as the ceiling.
    configure(-32768, -32768, -32768, 1, 1000, -1000);
    queue_request(OP_RESET,   16'h0000, 16'h0000, 32'd5000);
    queue_request(OP_COMPUTE, 16'h0400, 16'h0000, 32'd5001);
    queue_request(OP_COMPUTE, 16'h0000, 16'h0400, 32'd5002);
    queue_request(OP_COMPUTE, 16'h0042, 16'h0042, 32'd5003);
    queue_request(OP_COMPUTE, 16'h0042, 16'h0042, 32'd5003);
    settle_all();
    gen_ms = 32'd6000;

    // Random part. No pacing first, with a full pause halfway through.
    configure(384, 200, -77, 37, -8388608, 8388607);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(ItemsPerRun / 2);
    run_random(ItemsPerRun / 2);

    // Sender mostly idle, largest positive gains, no sample gating.
    configure(32767, 32767, 32767, 0, 0, 65280);
    sender_idle_pct    = 61;
    receiver_stall_pct = 0;
    run_random(ItemsPerRun);

    // Receiver mostly stalling, most negative gains, longest period.
    configure(-32768, -32768, -32768, 65535, -8388608, 8388607);
    sender_idle_pct    = 0;
    receiver_stall_pct = 61;
    run_random(ItemsPerRun);

    // Both sides pacing, random gains and inverted clamp limits.
    configure($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), 20, 5000, -5000);
    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    run_random(ItemsPerRun);

    // Back to free running with every register drawn at random.
    configure($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 500),
              $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(ItemsPerRun);

    // Let the pipeline run dry so that any stray result still gets caught.
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d requests (%0d controller resets), %0d results, %0d fresh updates.",
             requests_taken, resets_taken, results_seen, updates_seen);
    $display("Settings ranged over default, saturated and inverted clamps, periods 0..65535.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
